// File: rtl/laplacian_sharpen_3x3_defines.svh
// ----------------------------------------------------------------------------
// laplacian sharpen 3x3 assertion macros
// shared concurrent check forms, clocked on i_clk with i_rst_n as disable
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_DEFINES_SVH
`define LAPLACIAN_SHARPEN_3X3_DEFINES_SVH

// same-cycle implication
`define LSH_ASSERT_IMP(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("lsh check failed");

// next-cycle implication
`define LSH_ASSERT_NXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("lsh check failed");

`endif

// File: rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// shared constants, register codes and payload types of the sharpen filter
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 4'd3;

    // register reset values
    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic                    KMODE_RESET  = 1'b1;
    localparam logic                    OMODE_RESET  = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_req;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_tag;

    // [row][column], row 0 oldest line, column 0 oldest pixel
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

endpackage

`default_nettype wire

// File: rtl/lsh_stream_if.sv
// ----------------------------------------------------------------------------
// lsh_stream_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
`default_nettype none

interface lsh_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lsh_line_mem.sv
// ----------------------------------------------------------------------------
// lsh_line_mem
// one line store: single write port, registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_line_mem #(
    parameter int DEPTH = lsh_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [AW-1:0]            i_rd_addr,
    output logic [lsh_pkg::PIX_W-1:0]     o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [AW-1:0]            i_wr_addr,
    input  wire logic [lsh_pkg::PIX_W-1:0] i_wr_data
);

    logic [lsh_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [lsh_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/lsh_kernel.sv
// ----------------------------------------------------------------------------
// lsh_kernel
// laplacian correlation of one window, mode select and saturation, two stages
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_kernel (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire lsh_pkg::t_window i_win,
    input  wire lsh_pkg::t_tag    i_tag,
    input  wire logic             i_kernel_mode,
    input  wire logic             i_output_mode,
    lsh_stream_if.source          o_res
);

    // sum stage
    logic                        r_a_v;
    logic [10:0]                 r_sum;
    logic [10:0]                 r_cen;
    logic [lsh_pkg::PIX_W-1:0]   r_c;
    lsh_pkg::t_tag               r_a_tag;
    // output register
    logic                        r_o_v;
    lsh_pkg::t_pix_out           r_o;

    logic        a_fire;
    logic        in_fire;
    logic [10:0] cross_sum;
    logic [10:0] corner_sum;
    logic signed [11:0] lap;
    logic signed [12:0] res;
    logic [lsh_pkg::PIX_W-1:0] sat;

    assign a_fire  = r_a_v && (!r_o_v || o_res.ready);
    assign o_ready = !r_a_v || a_fire;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        cross_sum  = 11'(i_win[0][1]) + 11'(i_win[1][0]) + 11'(i_win[1][2]) + 11'(i_win[2][1]);
        corner_sum = 11'(i_win[0][0]) + 11'(i_win[0][2]) + 11'(i_win[2][0]) + 11'(i_win[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (in_fire) begin
                r_a_v <= 1'b1;
            end else if (a_fire) begin
                r_a_v <= 1'b0;
            end
            if (a_fire) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sum   <= i_kernel_mode ? (cross_sum + corner_sum) : cross_sum;
            r_cen   <= i_kernel_mode ? {i_win[1][1], 3'b000} : {1'b0, i_win[1][1], 2'b00};
            r_c     <= i_win[1][1];
            r_a_tag <= i_tag;
        end
    end

    always_comb begin
        lap = $signed({1'b0, r_sum}) - $signed({1'b0, r_cen});
        if (i_output_mode) begin
            res = $signed({5'b00000, r_c}) - $signed({lap[11], lap});
        end else begin
            res = $signed({lap[11], lap});
        end
        if (res[12]) begin
            sat = '0;
        end else if (res > 13'sd255) begin
            sat = '1;
        end else begin
            sat = res[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_o.pixel_out <= sat;
            r_o.row_end   <= r_a_tag.row_end;
            r_o.frame_end <= r_a_tag.frame_end;
        end
    end

    assign o_res.valid = r_o_v;
    assign o_res.data  = r_o;

endmodule

`default_nettype wire

// File: rtl/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 laplacian / sharpening filter over a raster-order grayscale stream
// ----------------------------------------------------------------------------
// usage
//   i_pix : pixel requests in raster order, frame_start marks row 0 column 0
//   o_pix : one result per pixel whose row and column are both at least 2,
//           value for the window centred one row up and one column left,
//           row_end / frame_end flag the last result of a row / frame
//   i_cfg : register writes (width, height, kernel mode, output mode),
//           always ready; the user writes only while no pixel is in flight, the block does not enforce it
//   throughput: one pixel per cycle while o_pix keeps up; each pixel does one read-modify-write
//           of the line stores on their single read and write ports
//   path: a result passes stage 1, the window, the kernel sum stage and the output register
//   stall: four stages buffer work, i_pix.ready drops only once they
//           are all full behind a stalled o_pix
//   reset: registers go to 640x480, eight-neighbour, sharpen mode; counters
//           and window clear; line stores keep their contents, no clear pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "laplacian_sharpen_3x3_defines.svh"

module laplacian_sharpen_3x3 #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lsh_stream_if.sink   i_pix,
    lsh_stream_if.source o_pix,
    lsh_stream_if.sink   i_cfg
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CW1 = CW + 1;
    localparam int WX  = (CW1 > lsh_pkg::WIDTH_CFG_W) ? CW1 : lsh_pkg::WIDTH_CFG_W;
    localparam int HW  = lsh_pkg::HEIGHT_CFG_W;
    localparam int RW  = lsh_pkg::ROW_W;
    localparam int PW  = lsh_pkg::PIX_W;

    // configuration registers
    logic [lsh_pkg::WIDTH_CFG_W-1:0]  r_image_width;
    logic [lsh_pkg::HEIGHT_CFG_W-1:0] r_image_height;
    logic                             r_kernel_mode;
    logic                             r_output_mode;

    // raster counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // stage 1: line store read in flight
    logic          r_s1_v;
    logic [PW-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_addr;
    logic          r_s1_produce;
    lsh_pkg::t_tag r_s1_tag;
    logic          r_fwd;
    logic [PW-1:0] r_fwd_a;
    logic [PW-1:0] r_fwd_b;

    // stage 2: window holds a complete neighbourhood
    lsh_pkg::t_window r_win;
    logic             r_s2_v;
    lsh_pkg::t_tag    r_s2_tag;

    logic          cfg_fire;
    logic          pix_fire;
    logic          s1_fire;
    logic          s2_ready;
    logic          s2_fire;
    logic          k_ready;
    logic [WX-1:0] w_raw;
    logic [CW1-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          last_col;
    logic          last_row;
    logic          produce;
    logic [PW-1:0] rd_a;
    logic [PW-1:0] rd_b;
    logic [PW-1:0] mid;
    logic [PW-1:0] top;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= lsh_pkg::WIDTH_RESET;
            r_image_height <= lsh_pkg::HEIGHT_RESET;
            r_kernel_mode  <= lsh_pkg::KMODE_RESET;
            r_output_mode  <= lsh_pkg::OMODE_RESET;
        end else if (cfg_fire) begin
            unique case (i_cfg.data.reg_index)
                lsh_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg.data.wr_data[lsh_pkg::WIDTH_CFG_W-1:0];
                end
                lsh_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg.data.wr_data[lsh_pkg::HEIGHT_CFG_W-1:0];
                end
                lsh_pkg::REG_KERNEL_MODE: begin
                    r_kernel_mode <= i_cfg.data.wr_data[0];
                end
                lsh_pkg::REG_OUTPUT_MODE: begin
                    r_output_mode <= i_cfg.data.wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        w_raw = WX'(r_image_width);
        if (w_raw < WX'(lsh_pkg::MIN_DIM)) begin
            w_eff = CW1'(lsh_pkg::MIN_DIM);
        end else if (w_raw > WX'(MAX_WIDTH)) begin
            w_eff = CW1'(MAX_WIDTH);
        end else begin
            w_eff = CW1'(w_raw);
        end
        if (r_image_height < HW'(lsh_pkg::MIN_DIM)) begin
            h_eff = HW'(lsh_pkg::MIN_DIM);
        end else if (r_image_height > HW'(lsh_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(lsh_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
    end

    // ------------------------------------------------------------------
    // handshake chain, ready flows back from the kernel stages
    // ------------------------------------------------------------------
    assign s2_fire     = r_s2_v && k_ready;
    assign s2_ready    = !r_s2_v || s2_fire;
    assign s1_fire     = r_s1_v && s2_ready;
    assign i_pix.ready = !r_s1_v || s1_fire;
    assign pix_fire    = i_pix.valid && i_pix.ready;

    // ------------------------------------------------------------------
    // raster position of the incoming pixel
    // ------------------------------------------------------------------
    always_comb begin
        col_cur  = i_pix.data.frame_start ? '0 : r_col;
        row_cur  = i_pix.data.frame_start ? '0 : r_row;
        last_col = ({1'b0, col_cur} + CW1'(1)) >= w_eff;
        last_row = (HW'(row_cur) + HW'(1)) >= h_eff;
        produce  = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
        // wrap at row end, and at frame end back to the top
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (row_cur + RW'(1));
        end else begin
            n_col = col_cur + CW'(1);
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (pix_fire) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_s1_v <= 1'b1;
                // write-back of the item ahead lands on the column being read
                r_fwd  <= s1_fire && (r_s1_addr == col_cur);
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_pix           <= i_pix.data.pixel_in;
            r_s1_addr          <= col_cur;
            r_s1_produce       <= produce;
            r_s1_tag.row_end   <= last_col;
            r_s1_tag.frame_end <= last_col && last_row;
            r_fwd_a            <= r_s1_pix;
            r_fwd_b            <= mid;
        end
    end

    // ------------------------------------------------------------------
    // line stores: read at request, write back when stage 1 moves on
    // store a holds the previous row, store b the row before that
    // ------------------------------------------------------------------
    lsh_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk     (i_clk),
        .i_rd_en   (pix_fire),
        .i_rd_addr (col_cur),
        .o_rd_data (rd_a),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_pix)
    );

    lsh_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk     (i_clk),
        .i_rd_en   (pix_fire),
        .i_rd_addr (col_cur),
        .o_rd_data (rd_b),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (mid)
    );

    // forwarded data stands in for the stale read
    assign mid = r_fwd ? r_fwd_a : rd_a;
    assign top = r_fwd ? r_fwd_b : rd_b;

    // ------------------------------------------------------------------
    // window shift, one column per pixel
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_fire) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= top;
            r_win[1][2] <= mid;
            r_win[2][2] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_fire) begin
            // border pixels only feed the window
            r_s2_v <= r_s1_produce;
        end else if (s2_fire) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // ------------------------------------------------------------------
    // kernel arithmetic and output register
    // ------------------------------------------------------------------
    lsh_kernel u_kernel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s2_v),
        .o_ready       (k_ready),
        .i_win         (r_win),
        .i_tag         (r_s2_tag),
        .i_kernel_mode (r_kernel_mode),
        .i_output_mode (r_output_mode),
        .o_res         (o_pix)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `LSH_ASSERT_IMP(a_frame_end_row_end, o_pix.valid && o_pix.data.frame_end, o_pix.data.row_end)
    `LSH_ASSERT_NXT(a_win_hold, r_s2_v && !s2_fire, $stable(r_win))
    `LSH_ASSERT_NXT(a_frame_restart, pix_fire && i_pix.data.frame_start, (r_col == CW'(1)) && (r_row == '0))

endmodule

`default_nettype wire
